@@ sv/bdpc_pkg.sv @@
// shared types and constants of the button debounce and press classifier
// no dependencies; imported by every module of the block

package bdpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_TIME = 1'd1;

  localparam logic [REG_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
  localparam logic [REG_W-1:0] LONG_PRESS_TIME_RST = 16'd600;

  typedef struct packed {
    logic              take_long;
    logic              take_short;
    logic [TIME_W-1:0] now_time;
    logic              raw_pressed;
  } bdpc_item_t;

  typedef struct packed {
    logic              debounced_level;
    logic              previous_raw;
    logic [TIME_W-1:0] edge_time;
    logic              edge_seen;
    logic [TIME_W-1:0] press_start_time;
    logic              press_start_valid;
    logic              long_fired;
    logic              short_flag;
    logic              long_flag;
  } bdpc_state_t;

  typedef struct packed {
    logic long_waiting;
    logic short_waiting;
    logic long_event;
    logic short_event;
    logic stable_level;
  } bdpc_result_t;

  typedef struct packed {
    logic [REG_W-1:0] debounce_time;
    logic [REG_W-1:0] long_press_time;
  } bdpc_cfg_t;

endpackage

@@ sv/button_debounce_press_classifier_top.sv @@
// top level of the button debounce and press classifier
// depends on bdpc_pkg and bdpc_core
//
// usage:
//   in_*  : one request per sample: raw level, millisecond time, two take strobes
//   out_* : exactly one result per request, in order
//   cfg_* : register writes (debounce time, long-press time), only while idle
// timing:
//   a request lands in the input register at its accept edge, the state update
//   runs combinationally on it and the result is captured in the output register
//   as the request advances, and out_tvalid rises with that capture
//   one request per cycle is sustained while out_tready is high; the state feedback
//   through bdpc_core is combinational, so consecutive samples need no spacing
// stalls:
//   while out_tready is low the result holds; the input register still takes
//   one more request, then in_tready drops until the output drains
// reset:
//   synchronous active-low rst_n empties both registers, clears all press state
//   and loads the default times (50 ms debounce, 600 ms long press)

module button_debounce_press_classifier_top import bdpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // raw_pressed[0], now_time[32:1], take_short[33], take_long[34], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // stable_level[0], short_event[1], long_event[2], short_waiting[3],
  // long_waiting[4], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_addr,
  input  logic [REG_W-1:0]       cfg_wdata
);

  bdpc_cfg_t    cfg_r;
  bdpc_state_t  state_r;
  bdpc_state_t  state_nxt;
  bdpc_item_t   item_r;
  logic         item_valid_r;
  bdpc_result_t res_r;
  bdpc_result_t res_nxt;
  logic         out_valid_r;
  logic         advance;
  logic         in_fire;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  bdpc_core u_core (
    .cfg       (cfg_r),
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg_r.long_press_time <= LONG_PRESS_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE_TIME:   cfg_r.debounce_time   <= cfg_wdata;
        REG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.raw_pressed <= in_tdata[0];
      item_r.now_time    <= in_tdata[TIME_W:1];
      item_r.take_short  <= in_tdata[TIME_W+1];
      item_r.take_long   <= in_tdata[TIME_W+2];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.long_waiting, res_r.short_waiting,
                       res_r.long_event, res_r.short_event, res_r.stable_level};

endmodule

@@ sv/bdpc_core.sv @@
// per-item update of the debounce and press classification state
// purely combinational; uses types from bdpc_pkg

module bdpc_core import bdpc_pkg::*; (
  input  bdpc_cfg_t    cfg,
  input  bdpc_state_t  state,
  input  bdpc_item_t   item,
  output bdpc_state_t  state_nxt,
  output bdpc_result_t result
);

  logic              raw_chg;
  logic [TIME_W-1:0] edge_age;
  logic              quiet;
  logic              stable_chg;
  logic [TIME_W-1:0] press_age;
  logic              long_hit;
  logic              short_ev;
  logic              long_ev;
  bdpc_state_t       s1;
  bdpc_state_t       s2;

  always_comb begin
    s1 = state;

    // any raw change restarts the debounce timer
    raw_chg = item.raw_pressed != state.previous_raw;
    s1.previous_raw = item.raw_pressed;
    if (raw_chg) begin
      s1.edge_time = item.now_time;
      s1.edge_seen = 1'b1;
    end

    edge_age   = item.now_time - s1.edge_time;
    quiet      = s1.edge_seen && (edge_age >= TIME_W'(cfg.debounce_time));
    stable_chg = quiet && (item.raw_pressed != state.debounced_level);

    if (stable_chg) begin
      s1.debounced_level = item.raw_pressed;
      if (item.raw_pressed) begin
        s1.press_start_time  = item.now_time;
        s1.press_start_valid = 1'b1;
        s1.long_fired        = 1'b0;
      end else if (!state.long_fired) begin
        s1.short_flag = 1'b1;
      end
    end

    s2 = s1;
    press_age = item.now_time - s1.press_start_time;
    long_hit  = s1.debounced_level && !s1.long_fired && s1.press_start_valid &&
                (press_age >= TIME_W'(cfg.long_press_time));
    if (long_hit) begin
      s2.long_fired = 1'b1;
      s2.long_flag  = 1'b1;
    end

    // consume strobes act after the update
    short_ev = item.take_short && s2.short_flag;
    long_ev  = item.take_long && s2.long_flag;
    if (short_ev) begin
      s2.short_flag = 1'b0;
    end
    if (long_ev) begin
      s2.long_flag = 1'b0;
    end

    state_nxt = s2;
    result.stable_level  = s2.debounced_level;
    result.short_event   = short_ev;
    result.long_event    = long_ev;
    result.short_waiting = s2.short_flag;
    result.long_waiting  = s2.long_flag;
  end

endmodule

@@ sv/bdpc_checker.sv @@
// port-level checks of the press classifier top level, attached by bind
// depends on bdpc_pkg

module bdpc_checker import bdpc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a taken flag is cleared in the same item
  a_short_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && out_tdata[3]))
    else $error("short event reported with short flag still waiting");

  a_long_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[4]))
    else $error("long event reported with long flag still waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  // input only backs up behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
